[rtl/core/ppcrp_pkg.sv]
// Shared codes for the PowerPC relocation patcher: relocation types,
// status codes, write sizes and field widths. No dependencies.
`default_nettype none

package ppcrp_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned TYPE_W   = 3;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned SIZE_W   = 2;
    // displacement S + A - P is exact at this width
    localparam int unsigned DISP_W   = 34;

    typedef logic [TYPE_W-1:0]   reloc_type_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SIZE_W-1:0]   wsize_t;
    typedef logic [WORD_W-1:0]   word_t;

    localparam reloc_type_t R_ADDR32    = 3'd0;
    localparam reloc_type_t R_ADDR16_LO = 3'd1;
    localparam reloc_type_t R_ADDR16_HI = 3'd2;
    localparam reloc_type_t R_ADDR16_HA = 3'd3;
    localparam reloc_type_t R_REL24     = 3'd4;
    localparam reloc_type_t R_REL32     = 3'd5;

    localparam status_t ST_OK     = 3'd0;
    localparam status_t ST_BOUNDS = 3'd1;
    localparam status_t ST_ALIGN  = 3'd2;
    localparam status_t ST_RANGE  = 3'd3;
    localparam status_t ST_IFORM  = 3'd4;
    localparam status_t ST_TYPE   = 3'd5;

    localparam wsize_t WS_NONE = 2'd0;
    localparam wsize_t WS_HALF = 2'd1;
    localparam wsize_t WS_WORD = 2'd2;

    localparam logic [5:0]        IFORM_OPCODE = 6'd18;
    localparam logic [WORD_W-1:0] HA_ROUND     = 32'h0000_8000;
    localparam logic [WORD_W:0]   HALF_BYTES   = 33'd2;
    localparam logic [WORD_W:0]   WORD_BYTES   = 33'd4;

endpackage

`default_nettype wire

[rtl/core/ppc_relocation_patcher_top.sv]
// PowerPC relocation patcher top level: input register, relocation logic,
// result register. Depends on ppcrp_pkg.
`default_nettype none

// Usage:
//   Request channel: drive start high with the relocation fields (req_type,
//   site_offset, symbol_address, addend, site_address, host_word). A request
//   is taken at every rising edge where start is high and busy is low; busy
//   is always low, so one request per cycle is sustained.
//   Result channel: done is high for exactly one cycle with status,
//   patched_value and write_size. The receiver cannot stall; every result
//   must be captured in the cycle it is shown.
//   Path: a request that is taken is held in the input register, and its
//   result is held in the result register, from which it is shown.
//   Throughput: one relocation per cycle, set by the single compare/add
//   stage between the two registers.
//   Configuration: cfg_we/cfg_wdata write section_size; the user must write it only while idle (not enforced).
//   Reset: rst_n clears section_size to 0 and drops all pending requests;
//   no result is shown until new requests arrive.
//   Failing checks give patched_value 0 and write_size 0.
module ppc_relocation_patcher_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ppcrp_pkg::WORD_W-1:0]   cfg_wdata,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [ppcrp_pkg::TYPE_W-1:0]   req_type,
    input  wire logic [ppcrp_pkg::WORD_W-1:0]   site_offset,
    input  wire logic [ppcrp_pkg::WORD_W-1:0]   symbol_address,
    input  wire logic signed [ppcrp_pkg::WORD_W-1:0] addend,
    input  wire logic [ppcrp_pkg::WORD_W-1:0]   site_address,
    input  wire logic [ppcrp_pkg::WORD_W-1:0]   host_word,
    output logic                                done,
    output logic [ppcrp_pkg::STATUS_W-1:0]      status,
    output logic [ppcrp_pkg::WORD_W-1:0]        patched_value,
    output logic [ppcrp_pkg::SIZE_W-1:0]        write_size
);

    localparam int unsigned W  = ppcrp_pkg::WORD_W;
    localparam int unsigned DW = ppcrp_pkg::DISP_W;

    logic [W-1:0] section_size_reg;

    logic                   in_valid_reg;
    ppcrp_pkg::reloc_type_t type_reg;
    logic [W-1:0]           offset_reg;
    logic [W-1:0]           sym_reg;
    logic [W-1:0]           addend_reg;
    logic [W-1:0]           site_reg;
    logic [W-1:0]           insn_reg;

    logic                   done_reg;
    ppcrp_pkg::status_t     status_reg;
    logic [W-1:0]           value_reg;
    ppcrp_pkg::wsize_t      size_reg;

    ppcrp_pkg::status_t     status_next;
    logic [W-1:0]           value_next;
    ppcrp_pkg::wsize_t      size_next;

    logic [W-1:0]  sum;
    logic [W-1:0]  sum_ha;
    logic [W:0]    half_end;
    logic [W:0]    word_end;
    logic          half_ok;
    logic          word_ok;
    logic [DW-1:0] disp;
    logic          rel24_in_range;
    logic          rel32_in_range;
    logic          accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            section_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg   <= req_type;
            offset_reg <= site_offset;
            sym_reg    <= symbol_address;
            addend_reg <= addend;
            site_reg   <= site_address;
            insn_reg   <= host_word;
        end
        if (in_valid_reg)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            size_reg   <= size_next;
        end
    end

    always_comb
    begin
        sum    = sym_reg + addend_reg;
        sum_ha = sum + ppcrp_pkg::HA_ROUND;

        // bounds at 33 bits so the end of the site never wraps
        half_end = {1'b0, offset_reg} + ppcrp_pkg::HALF_BYTES;
        word_end = {1'b0, offset_reg} + ppcrp_pkg::WORD_BYTES;
        half_ok  = half_end <= {1'b0, section_size_reg};
        word_ok  = word_end <= {1'b0, section_size_reg};

        // exact S + A - P: zero-extend S and P, sign-extend A
        disp = {{(DW-W){1'b0}}, sym_reg}
             + {{(DW-W){addend_reg[W-1]}}, addend_reg}
             - {{(DW-W){1'b0}}, site_reg};

        // in range when all bits above the signed field match its sign bit
        rel24_in_range = (&disp[DW-1:25]) || !(|disp[DW-1:25]);
        rel32_in_range = (&disp[DW-1:W-1]) || !(|disp[DW-1:W-1]);

        status_next = ppcrp_pkg::ST_OK;
        value_next  = '0;
        size_next   = ppcrp_pkg::WS_NONE;

        unique case (type_reg)
            ppcrp_pkg::R_ADDR32:
            begin
                if (!word_ok)
                begin
                    status_next = ppcrp_pkg::ST_BOUNDS;
                end
                else
                begin
                    value_next = sum;
                    size_next  = ppcrp_pkg::WS_WORD;
                end
            end
            ppcrp_pkg::R_ADDR16_LO:
            begin
                if (!half_ok)
                begin
                    status_next = ppcrp_pkg::ST_BOUNDS;
                end
                else
                begin
                    value_next = {16'h0000, sum[15:0]};
                    size_next  = ppcrp_pkg::WS_HALF;
                end
            end
            ppcrp_pkg::R_ADDR16_HI:
            begin
                if (!half_ok)
                begin
                    status_next = ppcrp_pkg::ST_BOUNDS;
                end
                else
                begin
                    value_next = {16'h0000, sum[31:16]};
                    size_next  = ppcrp_pkg::WS_HALF;
                end
            end
            ppcrp_pkg::R_ADDR16_HA:
            begin
                if (!half_ok)
                begin
                    status_next = ppcrp_pkg::ST_BOUNDS;
                end
                else
                begin
                    value_next = {16'h0000, sum_ha[31:16]};
                    size_next  = ppcrp_pkg::WS_HALF;
                end
            end
            ppcrp_pkg::R_REL24:
            begin
                if (!word_ok)
                begin
                    status_next = ppcrp_pkg::ST_BOUNDS;
                end
                else if (disp[1:0] != 2'b00)
                begin
                    status_next = ppcrp_pkg::ST_ALIGN;
                end
                else if (!rel24_in_range)
                begin
                    status_next = ppcrp_pkg::ST_RANGE;
                end
                else if (insn_reg[31:26] != ppcrp_pkg::IFORM_OPCODE)
                begin
                    status_next = ppcrp_pkg::ST_IFORM;
                end
                else
                begin
                    // keep opcode and AA/LK, drop in the word displacement
                    value_next = {insn_reg[31:26], disp[25:2], insn_reg[1:0]};
                    size_next  = ppcrp_pkg::WS_WORD;
                end
            end
            ppcrp_pkg::R_REL32:
            begin
                if (!word_ok)
                begin
                    status_next = ppcrp_pkg::ST_BOUNDS;
                end
                else if (!rel32_in_range)
                begin
                    status_next = ppcrp_pkg::ST_RANGE;
                end
                else
                begin
                    value_next = disp[W-1:0];
                    size_next  = ppcrp_pkg::WS_WORD;
                end
            end
            default:
            begin
                status_next = ppcrp_pkg::ST_TYPE;
            end
        endcase
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign patched_value = value_reg;
    assign write_size    = size_reg;

endmodule

`default_nettype wire
